### rtl/core/smsd_pkg.sv
// Shared types, constants and helper functions for the slave clock minute sync driver.
package smsd_pkg;

	// drive run shape
	localparam int RampSteps     = 9;
	localparam int MinutesPerDay = 1440;
	localparam int ResetShown    = 9 * 60 + 44;
	localparam int StepW         = $clog2(RampSteps + 1);

	// field widths
	localparam int CmdW    = 1;
	localparam int HourW   = 5;
	localparam int MinuteW = 6;
	localparam int SecondW = 6;
	localparam int LevelW  = 8;
	localparam int DurW    = 11;
	localparam int ShownW  = 12;
	localparam int TimeW   = 11;   // hour*60+minute+1 tops out at 1924

	// register widths and reset values
	localparam int StepMsW    = 8;
	localparam int HoldMsW    = 10;
	localparam int AheadW     = 6;
	localparam int StepMsRst  = 30;
	localparam int HoldMsRst  = 200;
	localparam int AheadRst   = 10;

	// APB port
	localparam int AddrW = 4;
	localparam int DataW = 32;
	localparam int RegIdxW = 2;

	localparam logic [LevelW-1:0] LevelFull = '1;
	localparam logic [LevelW-1:0] LevelOff  = '0;

	// command codes
	typedef enum logic [CmdW-1:0] {
		CMD_TICK = 1'b0,
		CMD_SET  = 1'b1
	} cmd_t;

	// register index codes (word address)
	typedef enum logic [RegIdxW-1:0] {
		REG_STEP_MS = 2'd0,
		REG_HOLD_MS = 2'd1,
		REG_AHEAD   = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [StepMsW-1:0] step_ms;
		logic [HoldMsW-1:0] hold_ms;
		logic [AheadW-1:0]  ahead_window;
	} cfg_t;

	// request from the decision stage to start one drive run
	typedef struct packed {
		logic                     start;
		logic                     even;
		logic signed [ShownW-1:0] after;
	} run_req_t;

	// drive level for ramp step k: 255 minus the ramp table entry
	function automatic logic [LevelW-1:0] ramp_level(input logic [StepW-1:0] k);
		logic [LevelW-1:0] v;
		begin
			case (k)
				4'd0:    v = 8'd0;
				4'd1:    v = 8'd4;
				4'd2:    v = 8'd8;
				4'd3:    v = 8'd16;
				4'd4:    v = 8'd32;
				4'd5:    v = 8'd64;
				4'd6:    v = 8'd128;
				4'd7:    v = 8'd192;
				default: v = 8'd255;
			endcase
			ramp_level = LevelFull - v;
		end
	endfunction

endpackage

### rtl/core/slave_clock_minute_sync_driver.sv
// Top level of the slave clock minute sync driver: register file, decision stage, drive sequencer.
//
// Usage:
//  - Input channel (in_valid / in_stall): one word per command. cmd = set loads
//    the shown minute from hour and minute (mod 1440); cmd = tick carries the
//    local time once per second and is compared against the shown minute.
//  - Output channel (out_valid / out_stall): a tick that finds the clock behind
//    produces one drive run of ten words: nine PWM ramp steps then one off step
//    with last = 1. Every word of a run carries the shown minute after the run.
//  - Flow: a word is registered in the input register and decided there; a
//    drive run is then started in the sequencer state, and its first word goes
//    on to the result register; words without results finish in the decision cycle.
//  - Throughput: one input word per cycle for set and idle ticks; a drive run
//    occupies the sequencer, one result word per cycle while out_stall is low, and runs
//    follow each other with no gap. A further run-causing tick waits in the
//    input register, which then raises in_stall.
//  - Output stall: the result register holds its word and the sequencer pauses;
//    input words keep flowing until a new run is needed.
//  - Reset (arst_n low): shown minute 09:44, step 30 ms, hold 200 ms, ahead
//    window 10 minutes, both channels empty.
module slave_clock_minute_sync_driver (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration port
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [smsd_pkg::AddrW-1:0]         paddr,
	input  logic [smsd_pkg::DataW-1:0]         pwdata,
	output logic [smsd_pkg::DataW-1:0]         prdata,
	output logic                               pready,
	// input words
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [smsd_pkg::CmdW-1:0]          cmd,
	input  logic [smsd_pkg::HourW-1:0]         hour,
	input  logic [smsd_pkg::MinuteW-1:0]       minute,
	input  logic [smsd_pkg::SecondW-1:0]       second,
	// result words
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [smsd_pkg::LevelW-1:0]        coil_a_level,
	output logic [smsd_pkg::LevelW-1:0]        coil_b_level,
	output logic [smsd_pkg::DurW-1:0]          duration_ms,
	output logic signed [smsd_pkg::ShownW-1:0] shown_after,
	output logic                               last
);

	smsd_pkg::cfg_t     cfg;
	smsd_pkg::run_req_t run_req;
	logic               can_start;

	// settings registers
	smsd_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// shown-minute state and per-word decision
	smsd_decide u_decide (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.hour      (hour),
		.minute    (minute),
		.second    (second),
		.cfg       (cfg),
		.can_start (can_start),
		.run_req   (run_req)
	);

	// ten-step drive run sequencer with result register
	smsd_drive u_drive (
		.clk          (clk),
		.arst_n       (arst_n),
		.run_req      (run_req),
		.cfg          (cfg),
		.can_start    (can_start),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.coil_a_level (coil_a_level),
		.coil_b_level (coil_b_level),
		.duration_ms  (duration_ms),
		.shown_after  (shown_after),
		.last         (last)
	);

endmodule

### rtl/core/smsd_cfg.sv
// APB register file holding step, hold and ahead-window settings.
module smsd_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [smsd_pkg::AddrW-1:0]    paddr,
	input  logic [smsd_pkg::DataW-1:0]    pwdata,
	output logic [smsd_pkg::DataW-1:0]    prdata,
	output logic                          pready,
	output smsd_pkg::cfg_t                cfg
);

	smsd_pkg::cfg_t   cfg_q;
	smsd_pkg::reg_idx_t idx;
	logic             wr_en;

	assign pready = 1'b1;
	assign idx    = smsd_pkg::reg_idx_t'(paddr[smsd_pkg::AddrW-1:2]);
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_ms      <= smsd_pkg::StepMsW'(smsd_pkg::StepMsRst);
			cfg_q.hold_ms      <= smsd_pkg::HoldMsW'(smsd_pkg::HoldMsRst);
			cfg_q.ahead_window <= smsd_pkg::AheadW'(smsd_pkg::AheadRst);
		end else if (wr_en) begin
			case (idx)
				smsd_pkg::REG_STEP_MS: cfg_q.step_ms <= pwdata[smsd_pkg::StepMsW-1:0];
				smsd_pkg::REG_HOLD_MS: cfg_q.hold_ms <= pwdata[smsd_pkg::HoldMsW-1:0];
				smsd_pkg::REG_AHEAD:   cfg_q.ahead_window <= pwdata[smsd_pkg::AheadW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			smsd_pkg::REG_STEP_MS: prdata = smsd_pkg::DataW'(cfg_q.step_ms);
			smsd_pkg::REG_HOLD_MS: prdata = smsd_pkg::DataW'(cfg_q.hold_ms);
			smsd_pkg::REG_AHEAD:   prdata = smsd_pkg::DataW'(cfg_q.ahead_window);
			default:               prdata = '0;
		endcase
	end

endmodule

### rtl/core/smsd_decide.sv
// Input register, shown-minute state and per-word decision (set, idle, drive, roll back).
module smsd_decide (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [smsd_pkg::CmdW-1:0]          cmd,
	input  logic [smsd_pkg::HourW-1:0]         hour,
	input  logic [smsd_pkg::MinuteW-1:0]       minute,
	input  logic [smsd_pkg::SecondW-1:0]       second,
	input  smsd_pkg::cfg_t                     cfg,
	input  logic                               can_start,
	output smsd_pkg::run_req_t                 run_req
);

	localparam int CmpW = smsd_pkg::ShownW + 1;

	logic                                valid_s1;
	logic [smsd_pkg::CmdW-1:0]           cmd_s1;
	logic [smsd_pkg::HourW-1:0]          hour_s1;
	logic [smsd_pkg::MinuteW-1:0]        minute_s1;
	logic [smsd_pkg::SecondW-1:0]        second_s1;
	logic signed [smsd_pkg::ShownW-1:0]  shown_q;

	logic [smsd_pkg::TimeW-1:0]          hour60;
	logic [smsd_pkg::TimeW-1:0]          base;
	logic [smsd_pkg::TimeW-1:0]          target;
	logic [smsd_pkg::TimeW-1:0]          set_val;
	logic [smsd_pkg::ShownW-1:0]         limit;
	logic signed [CmpW-1:0]              shown_x;
	logic signed [CmpW-1:0]              target_x;
	logic signed [CmpW-1:0]              limit_x;
	logic signed [smsd_pkg::ShownW-1:0]  inc;
	logic signed [smsd_pkg::ShownW-1:0]  after;
	logic                                is_set;
	logic                                behind;
	logic                                too_far;
	logic                                needs_run;
	logic                                adv;

	// hour*60 = hour*64 - hour*4
	assign hour60  = {hour_s1, 6'b0} - smsd_pkg::TimeW'({hour_s1, 2'b0});
	assign base    = hour60 + smsd_pkg::TimeW'(minute_s1);
	assign target  = base + smsd_pkg::TimeW'(second_s1 == smsd_pkg::SecondW'(59));
	assign set_val = (base >= smsd_pkg::TimeW'(smsd_pkg::MinutesPerDay))
		? base - smsd_pkg::TimeW'(smsd_pkg::MinutesPerDay) : base;
	assign limit   = smsd_pkg::ShownW'(target) + smsd_pkg::ShownW'(cfg.ahead_window);

	assign shown_x  = CmpW'(shown_q);
	assign target_x = signed'({2'b00, target});
	assign limit_x  = signed'({1'b0, limit});

	assign is_set  = (smsd_pkg::cmd_t'(cmd_s1) == smsd_pkg::CMD_SET);
	assign behind  = shown_x < target_x;
	assign too_far = shown_x > limit_x;

	assign inc   = shown_q + smsd_pkg::ShownW'(1);
	assign after = (inc == smsd_pkg::ShownW'(smsd_pkg::MinutesPerDay)) ? '0 : inc;

	assign needs_run = valid_s1 && !is_set && behind;
	assign adv       = !valid_s1 || !needs_run || can_start;
	assign in_stall  = valid_s1 && !adv;

	assign run_req.start = needs_run && can_start;
	assign run_req.even  = !shown_q[0];
	assign run_req.after = after;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			shown_q  <= smsd_pkg::ShownW'(smsd_pkg::ResetShown);
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (valid_s1 && adv) begin
				if (is_set) begin
					shown_q <= signed'(smsd_pkg::ShownW'(set_val));
				end else if (behind) begin
					shown_q <= after;
				end else if (too_far) begin
					shown_q <= shown_q - smsd_pkg::ShownW'(smsd_pkg::MinutesPerDay);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			cmd_s1    <= cmd;
			hour_s1   <= hour;
			minute_s1 <= minute;
			second_s1 <= second;
		end
	end

	a_shown_range: assert property (@(posedge clk) disable iff (!arst_n)
		(shown_q >= -smsd_pkg::ShownW'(smsd_pkg::MinutesPerDay)) &&
		(shown_q < smsd_pkg::ShownW'(smsd_pkg::MinutesPerDay)))
		else $error("shown minute out of range");

	a_hold_only_on_run: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> needs_run && !can_start)
		else $error("input stalled without a pending drive run");

endmodule

### rtl/core/smsd_drive.sv
// Drive run sequencer and result register: nine ramp steps and one off step per run.
module smsd_drive (
	input  logic                               clk,
	input  logic                               arst_n,
	input  smsd_pkg::run_req_t                 run_req,
	input  smsd_pkg::cfg_t                     cfg,
	output logic                               can_start,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [smsd_pkg::LevelW-1:0]        coil_a_level,
	output logic [smsd_pkg::LevelW-1:0]        coil_b_level,
	output logic [smsd_pkg::DurW-1:0]          duration_ms,
	output logic signed [smsd_pkg::ShownW-1:0] shown_after,
	output logic                               last
);

	localparam logic [smsd_pkg::StepW-1:0] OffStep   = smsd_pkg::StepW'(smsd_pkg::RampSteps);
	localparam logic [smsd_pkg::StepW-1:0] FinalRamp = smsd_pkg::StepW'(smsd_pkg::RampSteps - 1);

	logic                                active_q;
	logic [smsd_pkg::StepW-1:0]          step_q;
	logic                                even_q;
	logic signed [smsd_pkg::ShownW-1:0]  after_q;
	logic                                out_valid_q;
	logic [smsd_pkg::LevelW-1:0]         coil_a_q;
	logic [smsd_pkg::LevelW-1:0]         coil_b_q;
	logic [smsd_pkg::DurW-1:0]           dur_q;
	logic signed [smsd_pkg::ShownW-1:0]  after_out_q;
	logic                                last_q;

	logic                                out_free;
	logic                                is_off;
	logic [smsd_pkg::LevelW-1:0]         r;
	logic [smsd_pkg::LevelW-1:0]         lvl_a;
	logic [smsd_pkg::LevelW-1:0]         lvl_b;
	logic [smsd_pkg::DurW-1:0]           dur;

	assign out_free  = !out_valid_q || !out_stall;
	assign is_off    = (step_q == OffStep);
	assign can_start = !active_q || (out_free && is_off);

	assign r     = smsd_pkg::ramp_level(step_q);
	assign lvl_a = is_off ? smsd_pkg::LevelOff : (even_q ? r : smsd_pkg::LevelFull);
	assign lvl_b = is_off ? smsd_pkg::LevelOff : (even_q ? smsd_pkg::LevelFull : r);

	always_comb begin
		if (is_off) begin
			dur = '0;
		end else if (step_q == FinalRamp) begin
			dur = smsd_pkg::DurW'(cfg.step_ms) + smsd_pkg::DurW'(cfg.hold_ms);
		end else begin
			dur = smsd_pkg::DurW'(cfg.step_ms);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_free) begin
				out_valid_q <= active_q;
			end
			// a new run takes over right as the off step leaves
			if (run_req.start) begin
				active_q <= 1'b1;
				step_q   <= '0;
			end else if (out_free && active_q) begin
				step_q <= smsd_pkg::StepW'(step_q + 1'b1);
				if (is_off) begin
					active_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (run_req.start) begin
			even_q  <= run_req.even;
			after_q <= run_req.after;
		end
		if (out_free && active_q) begin
			coil_a_q    <= lvl_a;
			coil_b_q    <= lvl_b;
			dur_q       <= dur;
			after_out_q <= after_q;
			last_q      <= is_off;
		end
	end

	assign out_valid    = out_valid_q;
	assign coil_a_level = coil_a_q;
	assign coil_b_level = coil_b_q;
	assign duration_ms  = dur_q;
	assign shown_after  = after_out_q;
	assign last         = last_q;

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> step_q <= OffStep)
		else $error("drive step counter past off step");

	a_off_step_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && last_q |-> coil_a_q == '0 && coil_b_q == '0 && dur_q == '0)
		else $error("off step carries drive");

	a_start_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		run_req.start |-> can_start)
		else $error("run started while sequencer busy");

endmodule
